[hw/rtl/nsht_pkg.sv]
// types and constants shared by the noise source health test block
`default_nettype none

package nsht_pkg;

  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned FLAGS_W     = 3;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned RUN_W       = 8;
  localparam int unsigned SMALL_CNT_W = 7;
  localparam int unsigned LARGE_CNT_W = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [RUN_W-1:0]       RUN_MAX   = '1;
  localparam logic [SMALL_CNT_W-1:0] SMALL_MAX = '1;
  localparam logic [LARGE_CNT_W-1:0] LARGE_MAX = '1;

  localparam logic [RUN_W-1:0]       REPEAT_CUTOFF_RST = 8'd9;
  localparam logic [SMALL_CNT_W-1:0] SMALL_CUTOFF_RST  = 7'd18;
  localparam logic [LARGE_CNT_W-1:0] LARGE_CUTOFF_RST  = 13'd315;

  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_CUTOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_CUTOFF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_CUTOFF  = 2'd2;

  localparam int unsigned FLAG_REPEAT = 0;
  localparam int unsigned FLAG_SMALL  = 1;
  localparam int unsigned FLAG_LARGE  = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TEST_BYTE    = 2'd0,
    ACT_TEST_WORD    = 2'd1,
    ACT_CLEAR_FLAGS  = 2'd2,
    ACT_CLEAR_COUNTS = 2'd3
  } action_e;

  typedef struct packed {
    action_e               action;
    logic [SAMPLE_W-1:0]   byte0;
    logic [SAMPLE_W-1:0]   byte1;
    logic [SAMPLE_W-1:0]   byte2;
    logic [SAMPLE_W-1:0]   byte3;
  } item_t;

  typedef struct packed {
    logic [FLAGS_W-1:0]     error_flags;
    logic [COUNT_W-1:0]     total_errors;
    logic [COUNT_W-1:0]     repeat_errors;
    logic [COUNT_W-1:0]     small_window_errors;
    logic [COUNT_W-1:0]     large_window_errors;
    logic [RUN_W-1:0]       longest_run;
    logic [SMALL_CNT_W-1:0] most_small_matches;
    logic [LARGE_CNT_W-1:0] most_large_matches;
  } result_t;

  typedef struct packed {
    logic [RUN_W-1:0]       repeat_cutoff;
    logic [SMALL_CNT_W-1:0] small_cutoff;
    logic [LARGE_CNT_W-1:0] large_cutoff;
  } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/nsht_if.sv]
// valid/ready channel interfaces for sample items and results
`default_nettype none

interface nsht_item_if;
  logic                               valid;
  logic                               ready;
  logic [nsht_pkg::ACTION_W-1:0]      action;
  logic [nsht_pkg::SAMPLE_W-1:0]      byte0;
  logic [nsht_pkg::SAMPLE_W-1:0]      byte1;
  logic [nsht_pkg::SAMPLE_W-1:0]      byte2;
  logic [nsht_pkg::SAMPLE_W-1:0]      byte3;

  modport source (output valid, action, byte0, byte1, byte2, byte3, input ready);
  modport sink   (input valid, action, byte0, byte1, byte2, byte3, output ready);
endinterface

interface nsht_result_if;
  logic                               valid;
  logic                               ready;
  logic [nsht_pkg::FLAGS_W-1:0]       error_flags;
  logic [nsht_pkg::COUNT_W-1:0]       total_errors;
  logic [nsht_pkg::COUNT_W-1:0]       repeat_errors;
  logic [nsht_pkg::COUNT_W-1:0]       small_window_errors;
  logic [nsht_pkg::COUNT_W-1:0]       large_window_errors;
  logic [nsht_pkg::RUN_W-1:0]         longest_run;
  logic [nsht_pkg::SMALL_CNT_W-1:0]   most_small_matches;
  logic [nsht_pkg::LARGE_CNT_W-1:0]   most_large_matches;

  modport source (output valid, error_flags, total_errors, repeat_errors,
                  small_window_errors, large_window_errors, longest_run,
                  most_small_matches, most_large_matches, input ready);
  modport sink   (input valid, error_flags, total_errors, repeat_errors,
                  small_window_errors, large_window_errors, longest_run,
                  most_small_matches, most_large_matches, output ready);
endinterface

`default_nettype wire

[hw/rtl/noise_source_health_tests.sv]
// top level of the noise source health tests with channel registers
//
//   channel    dir  handshake     payload
//   item_i     in   valid/ready   action, byte0..byte3
//   result_o   out  valid/ready   error_flags, error counts, maxima
//   cfg        in   cfg_we_i      cfg_idx_i, cfg_wdata_i (write only)
//
// one item per cycle unless result_o stalls; each result goes through the input register and then
// the output register, which latches the single-pass test update
// the test state registers update once per item that leaves the input register, so items may follow back to back
// item_i.ready drops only while both registers hold data and result_o stalls
// reset clears all test state and counts and loads the default cutoffs
`default_nettype none

module noise_source_health_tests #(
  parameter int unsigned SMALL_WINDOW = 64,
  parameter int unsigned LARGE_WINDOW = 4096
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  nsht_item_if.sink                            item_i,
  nsht_result_if.source                        result_o,
  input  wire                                  cfg_we_i,
  input  wire  [nsht_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [nsht_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  nsht_pkg::cfg_t    cfg_q;
  nsht_pkg::item_t   in_q;
  nsht_pkg::result_t out_q;
  nsht_pkg::result_t res;
  logic              in_v_q, out_v_q;
  logic              in_take, advance;

  assign advance      = in_v_q && (!out_v_q || result_o.ready);
  assign item_i.ready = !in_v_q || advance;
  assign in_take      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_cutoff <= nsht_pkg::REPEAT_CUTOFF_RST;
      cfg_q.small_cutoff  <= nsht_pkg::SMALL_CUTOFF_RST;
      cfg_q.large_cutoff  <= nsht_pkg::LARGE_CUTOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nsht_pkg::CFG_REPEAT_CUTOFF: begin
          cfg_q.repeat_cutoff <= cfg_wdata_i[nsht_pkg::RUN_W-1:0];
        end
        nsht_pkg::CFG_SMALL_CUTOFF: begin
          cfg_q.small_cutoff <= cfg_wdata_i[nsht_pkg::SMALL_CNT_W-1:0];
        end
        nsht_pkg::CFG_LARGE_CUTOFF: begin
          cfg_q.large_cutoff <= cfg_wdata_i[nsht_pkg::LARGE_CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_q <= 1'b1;
      end else if (advance) begin
        in_v_q <= 1'b0;
      end
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.action <= nsht_pkg::action_e'(item_i.action);
      in_q.byte0  <= item_i.byte0;
      in_q.byte1  <= item_i.byte1;
      in_q.byte2  <= item_i.byte2;
      in_q.byte3  <= item_i.byte3;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  nsht_tests #(
    .SMALL_WINDOW (SMALL_WINDOW),
    .LARGE_WINDOW (LARGE_WINDOW)
  ) u_tests (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign result_o.valid               = out_v_q;
  assign result_o.error_flags         = out_q.error_flags;
  assign result_o.total_errors        = out_q.total_errors;
  assign result_o.repeat_errors       = out_q.repeat_errors;
  assign result_o.small_window_errors = out_q.small_window_errors;
  assign result_o.large_window_errors = out_q.large_window_errors;
  assign result_o.longest_run         = out_q.longest_run;
  assign result_o.most_small_matches  = out_q.most_small_matches;
  assign result_o.most_large_matches  = out_q.most_large_matches;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && out_v_q && !result_o.ready |-> !item_i.ready)
    else $error("input taken while both stages are full and output stalled");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(advance))
    else $error("result valid without an item leaving the input stage");

  a_clear_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.action == nsht_pkg::ACT_CLEAR_FLAGS |=> result_o.error_flags == '0)
    else $error("error flags not cleared");

  a_clear_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.action == nsht_pkg::ACT_CLEAR_COUNTS
      |=> result_o.total_errors == '0 && result_o.longest_run == '0)
    else $error("error counts not cleared");

endmodule

`default_nettype wire

[hw/rtl/nsht_tests.sv]
// test state and single-pass update of the repetition and window tests
`default_nettype none

module nsht_tests #(
  parameter int unsigned SMALL_WINDOW = 64,
  parameter int unsigned LARGE_WINDOW = 4096
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  nsht_pkg::item_t      item_i,
  input  nsht_pkg::cfg_t       cfg_i,
  output nsht_pkg::result_t    res_o
);

  localparam int unsigned SPosW = $clog2(SMALL_WINDOW + 4);
  localparam int unsigned LPosW = $clog2(LARGE_WINDOW + 4);

  logic [nsht_pkg::SAMPLE_W-1:0]    last_q, last_d;
  logic [nsht_pkg::RUN_W-1:0]       run_q, run_d;
  logic [nsht_pkg::SAMPLE_W-1:0]    sref_q, sref_d;
  logic [nsht_pkg::SMALL_CNT_W-1:0] smatch_q, smatch_d;
  logic [SPosW-1:0]                 spos_q, spos_d;
  logic [nsht_pkg::SAMPLE_W-1:0]    lref_q, lref_d;
  logic [nsht_pkg::LARGE_CNT_W-1:0] lmatch_q, lmatch_d;
  logic [LPosW-1:0]                 lpos_q, lpos_d;
  logic [nsht_pkg::FLAGS_W-1:0]     flags_q, flags_d;
  logic [nsht_pkg::COUNT_W-1:0]     cnt_total_q, cnt_total_d;
  logic [nsht_pkg::COUNT_W-1:0]     cnt_rep_q, cnt_rep_d;
  logic [nsht_pkg::COUNT_W-1:0]     cnt_small_q, cnt_small_d;
  logic [nsht_pkg::COUNT_W-1:0]     cnt_large_q, cnt_large_d;
  logic [nsht_pkg::RUN_W-1:0]       max_run_q, max_run_d;
  logic [nsht_pkg::SMALL_CNT_W-1:0] max_small_q, max_small_d;
  logic [nsht_pkg::LARGE_CNT_W-1:0] max_large_q, max_large_d;

  logic [3:0][nsht_pkg::SAMPLE_W-1:0] smp;
  assign smp = {item_i.byte3, item_i.byte2, item_i.byte1, item_i.byte0};

  // word-mode run chain
  logic [nsht_pkg::SAMPLE_W-1:0] w_last;
  logic [nsht_pkg::RUN_W-1:0]    w_run;
  always_comb begin
    w_last = last_q;
    w_run  = run_q;
    for (int i = 0; i < 4; i++) begin
      if (smp[i] == w_last) begin
        if (w_run != nsht_pkg::RUN_MAX) begin
          w_run = w_run + nsht_pkg::RUN_W'(1);
        end
      end else begin
        w_last = smp[i];
        w_run  = nsht_pkg::RUN_W'(1);
      end
    end
  end

  // word-mode match sums
  logic                          s_restart, l_restart;
  logic [nsht_pkg::SAMPLE_W-1:0] s_wref, l_wref;
  logic [2:0]                    s_nhit, l_nhit;
  logic [nsht_pkg::SMALL_CNT_W:0] s_sum;
  logic [nsht_pkg::LARGE_CNT_W:0] l_sum;
  logic [nsht_pkg::SMALL_CNT_W-1:0] s_wmatch;
  logic [nsht_pkg::LARGE_CNT_W-1:0] l_wmatch;

  assign s_restart = (spos_q >= SPosW'(SMALL_WINDOW));
  assign l_restart = (lpos_q >= LPosW'(LARGE_WINDOW));
  assign s_wref    = s_restart ? smp[0] : sref_q;
  assign l_wref    = l_restart ? smp[0] : lref_q;

  always_comb begin
    s_nhit = '0;
    l_nhit = '0;
    for (int i = 0; i < 4; i++) begin
      if (i != 0 || !s_restart) begin
        s_nhit = s_nhit + 3'(smp[i] == s_wref);
      end
      if (i != 0 || !l_restart) begin
        l_nhit = l_nhit + 3'(smp[i] == l_wref);
      end
    end
    s_sum = (s_restart ? '0 : {1'b0, smatch_q}) + (nsht_pkg::SMALL_CNT_W + 1)'(s_nhit);
    l_sum = (l_restart ? '0 : {1'b0, lmatch_q}) + (nsht_pkg::LARGE_CNT_W + 1)'(l_nhit);
    s_wmatch = s_sum[nsht_pkg::SMALL_CNT_W] ? nsht_pkg::SMALL_MAX
                                            : s_sum[nsht_pkg::SMALL_CNT_W-1:0];
    l_wmatch = l_sum[nsht_pkg::LARGE_CNT_W] ? nsht_pkg::LARGE_MAX
                                            : l_sum[nsht_pkg::LARGE_CNT_W-1:0];
  end

  // test update and checks
  logic                         run_chk, s_chk, l_chk;
  logic [nsht_pkg::FLAGS_W-1:0] fail;

  always_comb begin
    last_d      = last_q;
    run_d       = run_q;
    sref_d      = sref_q;
    smatch_d    = smatch_q;
    spos_d      = spos_q;
    lref_d      = lref_q;
    lmatch_d    = lmatch_q;
    lpos_d      = lpos_q;
    flags_d     = flags_q;
    cnt_total_d = cnt_total_q;
    cnt_rep_d   = cnt_rep_q;
    cnt_small_d = cnt_small_q;
    cnt_large_d = cnt_large_q;
    max_run_d   = max_run_q;
    max_small_d = max_small_q;
    max_large_d = max_large_q;
    run_chk     = 1'b0;
    s_chk       = 1'b0;
    l_chk       = 1'b0;

    case (item_i.action)
      nsht_pkg::ACT_TEST_BYTE: begin
        if (smp[0] == last_q) begin
          run_chk = 1'b1;
          if (run_q != nsht_pkg::RUN_MAX) begin
            run_d = run_q + nsht_pkg::RUN_W'(1);
          end
        end else begin
          last_d = smp[0];
          run_d  = nsht_pkg::RUN_W'(1);
        end
        if (s_restart) begin
          sref_d   = smp[0];
          spos_d   = SPosW'(1);
          smatch_d = '0;
        end else begin
          spos_d = spos_q + SPosW'(1);
          if (smp[0] == sref_q) begin
            s_chk = 1'b1;
            if (smatch_q != nsht_pkg::SMALL_MAX) begin
              smatch_d = smatch_q + nsht_pkg::SMALL_CNT_W'(1);
            end
          end
        end
        if (l_restart) begin
          lref_d   = smp[0];
          lpos_d   = LPosW'(1);
          lmatch_d = '0;
        end else begin
          lpos_d = lpos_q + LPosW'(1);
          if (smp[0] == lref_q) begin
            l_chk = 1'b1;
            if (lmatch_q != nsht_pkg::LARGE_MAX) begin
              lmatch_d = lmatch_q + nsht_pkg::LARGE_CNT_W'(1);
            end
          end
        end
      end
      nsht_pkg::ACT_TEST_WORD: begin
        last_d   = w_last;
        run_d    = w_run;
        run_chk  = 1'b1;
        sref_d   = s_wref;
        spos_d   = s_restart ? SPosW'(4) : spos_q + SPosW'(4);
        smatch_d = s_wmatch;
        s_chk    = 1'b1;
        lref_d   = l_wref;
        lpos_d   = l_restart ? LPosW'(4) : lpos_q + LPosW'(4);
        lmatch_d = l_wmatch;
        l_chk    = 1'b1;
      end
      nsht_pkg::ACT_CLEAR_FLAGS: begin
        flags_d = '0;
      end
      default: begin
        cnt_total_d = '0;
        cnt_rep_d   = '0;
        cnt_small_d = '0;
        cnt_large_d = '0;
        max_run_d   = '0;
        max_small_d = '0;
        max_large_d = '0;
      end
    endcase

    fail[nsht_pkg::FLAG_REPEAT] = run_chk && (run_d >= cfg_i.repeat_cutoff);
    fail[nsht_pkg::FLAG_SMALL]  = s_chk && (smatch_d > cfg_i.small_cutoff);
    fail[nsht_pkg::FLAG_LARGE]  = l_chk && (lmatch_d > cfg_i.large_cutoff);

    if (run_chk && (run_d > max_run_q)) begin
      max_run_d = run_d;
    end
    if (s_chk && (smatch_d > max_small_q)) begin
      max_small_d = smatch_d;
    end
    if (l_chk && (lmatch_d > max_large_q)) begin
      max_large_d = lmatch_d;
    end

    flags_d     = flags_d | fail;
    cnt_total_d = cnt_total_d + nsht_pkg::COUNT_W'($countones(fail));
    cnt_rep_d   = cnt_rep_d + nsht_pkg::COUNT_W'(fail[nsht_pkg::FLAG_REPEAT]);
    cnt_small_d = cnt_small_d + nsht_pkg::COUNT_W'(fail[nsht_pkg::FLAG_SMALL]);
    cnt_large_d = cnt_large_d + nsht_pkg::COUNT_W'(fail[nsht_pkg::FLAG_LARGE]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      run_q       <= '0;
      sref_q      <= '0;
      smatch_q    <= '0;
      spos_q      <= '0;
      lref_q      <= '0;
      lmatch_q    <= '0;
      lpos_q      <= '0;
      flags_q     <= '0;
      cnt_total_q <= '0;
      cnt_rep_q   <= '0;
      cnt_small_q <= '0;
      cnt_large_q <= '0;
      max_run_q   <= '0;
      max_small_q <= '0;
      max_large_q <= '0;
    end else if (step_i) begin
      last_q      <= last_d;
      run_q       <= run_d;
      sref_q      <= sref_d;
      smatch_q    <= smatch_d;
      spos_q      <= spos_d;
      lref_q      <= lref_d;
      lmatch_q    <= lmatch_d;
      lpos_q      <= lpos_d;
      flags_q     <= flags_d;
      cnt_total_q <= cnt_total_d;
      cnt_rep_q   <= cnt_rep_d;
      cnt_small_q <= cnt_small_d;
      cnt_large_q <= cnt_large_d;
      max_run_q   <= max_run_d;
      max_small_q <= max_small_d;
      max_large_q <= max_large_d;
    end
  end

  always_comb begin
    res_o.error_flags         = flags_d;
    res_o.total_errors        = cnt_total_d;
    res_o.repeat_errors       = cnt_rep_d;
    res_o.small_window_errors = cnt_small_d;
    res_o.large_window_errors = cnt_large_d;
    res_o.longest_run         = max_run_d;
    res_o.most_small_matches  = max_small_d;
    res_o.most_large_matches  = max_large_d;
  end

endmodule

`default_nettype wire
